// File: sv/vprm_pkg.sv
package vprm_pkg;
  // Q1.14 scaling; the 16-bit fields fix it
  localparam int FRAC_BITS = 14;

  typedef struct packed {
    logic [1:0] row;
    logic [14:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
    logic signed [15:0] col0;
    logic signed [15:0] col1;
    logic signed [15:0] col2;
    logic [15:0] inf_norm;
    logic degenerate;
    logic last;
  } row_beat_t;
endpackage

// File: sv/vprm_core.sv
module vprm_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [15:0] ax, ay, az, bx, by, bz,
  output logic out_valid,
  input  logic out_ready,
  output logic [14:0] q_w,
  output logic signed [15:0] q_x, q_y, q_z,
  output logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output logic [15:0] norm,
  output logic degen
);
  import vprm_pkg::*;
  localparam int PW = 36;
  localparam int SW = 2 * FRAC_BITS + 3;
  localparam int RW = FRAC_BITS + 2;
  localparam int QW = 34;
  localparam int NSQ = (SW + 1) / 2;
  localparam int NDIV = QW;
  localparam int NST = 2 + NSQ + NDIV + 3;
  localparam logic signed [SW:0] ONE_SQ = (SW + 1)'(1) <<< (2 * FRAC_BITS);
  localparam logic signed [RW:0] ONE = (RW + 1)'(1) <<< FRAC_BITS;

  logic adv;
  logic [NST-1:0] v;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  logic signed [PW-1:0] p0 [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      p0[0] <= PW'(ax * bx); p0[1] <= PW'(ay * by); p0[2] <= PW'(az * bz);
      p0[3] <= PW'(ay * bz); p0[4] <= PW'(az * by); p0[5] <= PW'(az * bx);
      p0[6] <= PW'(ax * bz); p0[7] <= PW'(ax * by); p0[8] <= PW'(ay * bx);
    end
  end

  logic signed [PW+1:0] s1, n1 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= (PW + 2)'(ONE_SQ) + p0[0] + p0[1] + p0[2];
      n1[0] <= p0[3] - p0[4];
      n1[1] <= p0[5] - p0[6];
      n1[2] <= p0[7] - p0[8];
    end
  end

  // Square root: one result bit per stage.
  localparam int XW = PW + 2;
  logic [XW-1:0] sr_rem [NSQ+1];
  logic [XW-1:0] sr_res [NSQ+1];
  logic [XW-1:0] sr_x [NSQ+1];
  logic sr_pos [NSQ+1];
  logic signed [PW+1:0] sr_n [NSQ+1][3];
  always_comb begin
    sr_x[0] = (s1 > 0) ? XW'(s1 >>> 1) : '0;
    sr_rem[0] = '0;
    sr_res[0] = '0;
    sr_pos[0] = s1 > 0;
    sr_n[0] = n1;
  end
  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    logic [XW-1:0] trial;
    logic [XW-1:0] rem2;
    always_comb begin
      rem2 = (sr_rem[i] << 2) | XW'(sr_x[i][2*(NSQ-1-i) +: 2]);
      trial = (sr_res[i] << 2) | XW'(1);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sr_x[i+1] <= sr_x[i];
        sr_pos[i+1] <= sr_pos[i];
        sr_n[i+1] <= sr_n[i];
        if (rem2 >= trial) begin
          sr_rem[i+1] <= rem2 - trial;
          sr_res[i+1] <= (sr_res[i] << 1) | XW'(1);
        end else begin
          sr_rem[i+1] <= rem2;
          sr_res[i+1] <= sr_res[i] << 1;
        end
      end
    end
  end

  logic [RW-1:0] w_s;
  logic dg_s;
  always_comb begin
    w_s = (sr_res[NSQ] > XW'(ONE)) ? RW'(ONE) : RW'(sr_res[NSQ]);
    dg_s = !sr_pos[NSQ] || (w_s == '0);
    if (dg_s) w_s = RW'(ONE);
  end

  // Rounded division of three numerators by 2w, restoring, one bit per stage.
  logic [QW-1:0] dv_num [NDIV+1][3];
  logic [QW:0] dv_rem [NDIV+1][3];
  logic [QW-1:0] dv_q [NDIV+1][3];
  logic dv_neg [NDIV+1][3];
  logic [RW:0] dv_d [NDIV+1];
  logic [RW-1:0] dv_w [NDIV+1];
  logic dv_dg [NDIV+1];
  always_comb begin
    dv_d[0] = {w_s, 1'b0};
    dv_w[0] = w_s;
    dv_dg[0] = dg_s;
    for (int k = 0; k < 3; k++) begin
      dv_neg[0][k] = sr_n[NSQ][k] < 0;
      dv_num[0][k] = QW'(sr_n[NSQ][k] < 0 ? -sr_n[NSQ][k] : sr_n[NSQ][k])
                     + QW'(w_s);
      dv_rem[0][k] = '0;
      dv_q[0][k] = '0;
    end
  end
  for (genvar i = 0; i < NDIV; i++) begin : g_dv
    logic [QW:0] r2 [3];
    always_comb begin
      for (int k = 0; k < 3; k++)
        r2[k] = {dv_rem[i][k][QW-1:0], dv_num[i][k][QW-1-i]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_d[i+1] <= dv_d[i];
        dv_w[i+1] <= dv_w[i];
        dv_dg[i+1] <= dv_dg[i];
        for (int k = 0; k < 3; k++) begin
          dv_num[i+1][k] <= dv_num[i][k];
          dv_neg[i+1][k] <= dv_neg[i][k];
          if (r2[k] >= (QW + 1)'(dv_d[i])) begin
            dv_rem[i+1][k] <= r2[k] - (QW + 1)'(dv_d[i]);
            dv_q[i+1][k] <= dv_q[i][k] | (QW'(1) << (QW - 1 - i));
          end else begin
            dv_rem[i+1][k] <= r2[k];
            dv_q[i+1][k] <= dv_q[i][k];
          end
        end
      end
    end
  end

  logic signed [RW:0] qs [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_dg[NDIV]) qs[k] = '0;
      else if (dv_q[NDIV][k] > QW'(ONE)) qs[k] = dv_neg[NDIV][k] ? -ONE : ONE;
      else qs[k] = dv_neg[NDIV][k] ? -(RW + 1)'(dv_q[NDIV][k])
                                   : (RW + 1)'(dv_q[NDIV][k]);
    end
  end

  // Products stage.
  logic signed [RW:0] wq, xq, yq, zq;
  logic dg_p;
  logic signed [2*RW+1:0] pr [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      wq <= (RW + 1)'(dv_w[NDIV]); xq <= qs[0]; yq <= qs[1]; zq <= qs[2];
      dg_p <= dv_dg[NDIV];
      pr[0] <= (2 * RW + 2)'(qs[0] * qs[0]);
      pr[1] <= (2 * RW + 2)'(qs[1] * qs[1]);
      pr[2] <= (2 * RW + 2)'(qs[2] * qs[2]);
      pr[3] <= (2 * RW + 2)'(qs[0] * qs[1]);
      pr[4] <= (2 * RW + 2)'(qs[0] * qs[2]);
      pr[5] <= (2 * RW + 2)'(qs[1] * qs[2]);
      pr[6] <= (2 * RW + 2)'($signed({1'b0, dv_w[NDIV]}) * qs[0]);
      pr[7] <= (2 * RW + 2)'($signed({1'b0, dv_w[NDIV]}) * qs[1]);
      pr[8] <= (2 * RW + 2)'($signed({1'b0, dv_w[NDIV]}) * qs[2]);
    end
  end

  localparam int EW = 2 * RW + 4;
  logic signed [EW-1:0] e [9];
  always_comb begin
    e[0] = EW'(ONE_SQ) - 2 * (EW'(pr[1]) + EW'(pr[2]));
    e[1] = 2 * (EW'(pr[3]) - EW'(pr[8]));
    e[2] = 2 * (EW'(pr[4]) + EW'(pr[7]));
    e[3] = 2 * (EW'(pr[3]) + EW'(pr[8]));
    e[4] = EW'(ONE_SQ) - 2 * (EW'(pr[2]) + EW'(pr[0]));
    e[5] = 2 * (EW'(pr[5]) - EW'(pr[6]));
    e[6] = 2 * (EW'(pr[4]) - EW'(pr[7]));
    e[7] = 2 * (EW'(pr[5]) + EW'(pr[6]));
    e[8] = EW'(ONE_SQ) - 2 * (EW'(pr[1]) + EW'(pr[0]));
  end

  function automatic logic signed [RW:0] rnd(input logic signed [EW-1:0] x);
    logic [EW-1:0] m;
    logic [EW-1:0] r;
    logic signed [RW:0] o;
    m = x < 0 ? EW'(-x) : EW'(x);
    r = (m + (EW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    o = (r > EW'(ONE)) ? ONE : (RW + 1)'(r);
    return x < 0 ? -o : o;
  endfunction

  logic signed [RW:0] mm [9];
  logic signed [RW:0] w2, x2, y2, z2;
  logic dg2;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) mm[k] <= rnd(e[k]);
      w2 <= wq; x2 <= xq; y2 <= yq; z2 <= zq; dg2 <= dg_p;
    end
  end

  logic [RW+2:0] rs [3];
  logic [RW+2:0] mx;
  always_comb begin
    for (int r = 0; r < 3; r++)
      rs[r] = (RW + 3)'(mm[3*r][RW] ? -mm[3*r] : mm[3*r])
            + (RW + 3)'(mm[3*r+1][RW] ? -mm[3*r+1] : mm[3*r+1])
            + (RW + 3)'(mm[3*r+2][RW] ? -mm[3*r+2] : mm[3*r+2]);
    mx = rs[0];
    if (rs[1] > mx) mx = rs[1];
    if (rs[2] > mx) mx = rs[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NST-2:0], in_valid};
    end
  end
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      q_w <= 15'(w2); q_x <= 16'(x2); q_y <= 16'(y2); q_z <= 16'(z2);
      m00 <= 16'(mm[0]); m01 <= 16'(mm[1]); m02 <= 16'(mm[2]);
      m10 <= 16'(mm[3]); m11 <= 16'(mm[4]); m12 <= 16'(mm[5]);
      m20 <= 16'(mm[6]); m21 <= 16'(mm[7]); m22 <= 16'(mm[8]);
      norm <= (mx > (RW + 3)'(16'hFFFF)) ? 16'hFFFF : 16'(mx);
      degen <= dg2;
    end
  end

  a_deg_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && degen |-> q_x == 0 && q_y == 0 && q_z == 0)
    else $error("degenerate item carries nonzero axis");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(q_w))
    else $error("core result lost during stall");
  a_norm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> norm >= 16'(m00[15] ? -m00 : m00))
    else $error("norm below first row entry");
endmodule

// File: sv/vector_pair_rotation_matrix.sv
// Shortest-arc rotation from vector pair a,b (signed Q1.14) to a 3x3 rotation matrix.
// Each accepted input beat yields three output beats, rows 0,1,2, each repeating the
// quaternion; tlast marks row 2, which also carries the infinity norm. Opposite or
// near-opposite vectors raise the degenerate flag and output the identity. The path from
// the input beat to the row 0 beat is 2 product/sum stages, a 16-stage bit-per-stage
// square root, a 34-stage bit-per-stage divider, then matrix products, rounding and
// the output register. The pipeline takes a beat every cycle, but the row serializer
// emits three beats per item and holds the whole pipeline while it walks rows 0 and 1,
// and while the output stalls, so it takes at most one item per three output beats.
module vector_pair_rotation_matrix (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // ax[15:0], ay[31:16], az[47:32], bx[63:48], by[79:64], bz[95:80]
  input  logic [95:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // row[1:0], q_w[16:2], q_x[32:17], q_y[48:33], q_z[64:49], col0[80:65],
  // col1[96:81], col2[112:97], inf_norm[128:113], pad zeros to 136
  output logic [135:0] m_axis_tdata,
  // degenerate
  output logic m_axis_tuser,
  output logic m_axis_tlast
);
  import vprm_pkg::*;

  logic c_valid, c_ready, degen;
  logic [14:0] q_w;
  logic signed [15:0] q_x, q_y, q_z, m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic [15:0] norm;
  logic [1:0] row;
  row_beat_t beat;

  vprm_core u_core (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .ax(s_axis_tdata[15:0]), .ay(s_axis_tdata[31:16]), .az(s_axis_tdata[47:32]),
    .bx(s_axis_tdata[63:48]), .by(s_axis_tdata[79:64]), .bz(s_axis_tdata[95:80]),
    .out_valid(c_valid), .out_ready(c_ready),
    .q_w, .q_x, .q_y, .q_z, .m00, .m01, .m02, .m10, .m11, .m12, .m20, .m21, .m22,
    .norm, .degen
  );

  // Walk rows of the held core result; release it after row 2.
  assign m_axis_tvalid = c_valid;
  assign c_ready = m_axis_tready && (row == 2'd2);
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      row <= (row == 2'd2) ? 2'd0 : row + 2'd1;
    end
  end

  always_comb begin
    beat.row = row;
    beat.q_w = q_w; beat.q_x = q_x; beat.q_y = q_y; beat.q_z = q_z;
    beat.degenerate = degen;
    beat.last = row == 2'd2;
    beat.inf_norm = (row == 2'd2) ? norm : '0;
    case (row)
      2'd0: begin beat.col0 = m00; beat.col1 = m01; beat.col2 = m02; end
      2'd1: begin beat.col0 = m10; beat.col1 = m11; beat.col2 = m12; end
      default: begin beat.col0 = m20; beat.col1 = m21; beat.col2 = m22; end
    endcase
  end

  assign m_axis_tdata = {7'd0, beat.inf_norm, beat.col2, beat.col1, beat.col0,
                         beat.q_z, beat.q_y, beat.q_x, beat.q_w, beat.row};
  assign m_axis_tuser = beat.degenerate;
  assign m_axis_tlast = beat.last;

  a_row: assert property (@(posedge clk) disable iff (rst) row != 2'd3)
    else $error("row counter out of range");
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("item dropped mid rows");
  a_norm0: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[128:113] == 16'd0)
    else $error("norm on non-last row");
endmodule

// File: sim/vprm_checker.sv
module vprm_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [135:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         m_axis_tlast,
  output int           mismatches,
  output int           rows_pending
);
  import vprm_pkg::*;
  localparam int FRAC = 14;
  localparam longint ONE = longint'(1) << FRAC;
  localparam longint ONE_SQ = longint'(1) << (2 * FRAC);

  row_beat_t expected_rows[$];

  function automatic longint floor_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint clamp_one(input longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic longint abs_l(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // num / den, rounded half away from zero
  function automatic longint div_nearest(input longint num, input longint den);
    longint m;
    m = (abs_l(num) + den / 2) / den;
    return num < 0 ? -m : m;
  endfunction

  // drop FRAC bits, rounded half away from zero
  function automatic longint scale_nearest(input longint v);
    longint m;
    m = (abs_l(v) + (longint'(1) << (FRAC - 1))) >> FRAC;
    return v < 0 ? -m : m;
  endfunction

  task automatic predict_rotation(input logic [95:0] d);
    longint a0, a1, a2, b0, b1, b2, c, n0, n1, n2, s, w, x, y, z, norm, sum;
    longint e[3][3];
    longint mx[3][3];
    bit degen;
    row_beat_t rb;
    a0 = longint'($signed(d[15:0]));
    a1 = longint'($signed(d[31:16]));
    a2 = longint'($signed(d[47:32]));
    b0 = longint'($signed(d[63:48]));
    b1 = longint'($signed(d[79:64]));
    b2 = longint'($signed(d[95:80]));
    c = a0 * b0 + a1 * b1 + a2 * b2;
    n0 = a1 * b2 - a2 * b1;
    n1 = a2 * b0 - a0 * b2;
    n2 = a0 * b1 - a1 * b0;
    s = ONE_SQ + c;
    degen = 1;
    w = 0;
    if (s > 0) begin
      w = floor_sqrt(longint'(s) >> 1);
      if (w > ONE) w = ONE;
      if (w > 0) degen = 0;
    end
    // opposite or near-opposite vectors: fall back to the identity
    if (degen) begin
      w = ONE; x = 0; y = 0; z = 0;
    end else begin
      x = clamp_one(div_nearest(n0, 2 * w));
      y = clamp_one(div_nearest(n1, 2 * w));
      z = clamp_one(div_nearest(n2, 2 * w));
    end
    e[0][0] = ONE_SQ - 2 * (y * y + z * z);
    e[0][1] = 2 * (x * y - w * z);
    e[0][2] = 2 * (x * z + w * y);
    e[1][0] = 2 * (x * y + w * z);
    e[1][1] = ONE_SQ - 2 * (z * z + x * x);
    e[1][2] = 2 * (y * z - w * x);
    e[2][0] = 2 * (x * z - w * y);
    e[2][1] = 2 * (y * z + w * x);
    e[2][2] = ONE_SQ - 2 * (y * y + x * x);
    norm = 0;
    for (int r = 0; r < 3; r++) begin
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        mx[r][k] = clamp_one(scale_nearest(e[r][k]));
        sum += abs_l(mx[r][k]);
      end
      if (sum > norm) norm = sum;
    end
    if (norm > 65535) norm = 65535;
    for (int r = 0; r < 3; r++) begin
      rb.row        = 2'(r);
      rb.q_w        = w[14:0];
      rb.q_x        = x[15:0];
      rb.q_y        = y[15:0];
      rb.q_z        = z[15:0];
      rb.col0       = mx[r][0][15:0];
      rb.col1       = mx[r][1][15:0];
      rb.col2       = mx[r][2][15:0];
      rb.inf_norm   = (r == 2) ? norm[15:0] : 16'd0;
      rb.degenerate = degen;
      rb.last       = (r == 2);
      expected_rows.push_back(rb);
    end
  endtask

  row_beat_t got, want;

  always_comb begin
    got.row        = m_axis_tdata[1:0];
    got.q_w        = m_axis_tdata[16:2];
    got.q_x        = m_axis_tdata[32:17];
    got.q_y        = m_axis_tdata[48:33];
    got.q_z        = m_axis_tdata[64:49];
    got.col0       = m_axis_tdata[80:65];
    got.col1       = m_axis_tdata[96:81];
    got.col2       = m_axis_tdata[112:97];
    got.inf_norm   = m_axis_tdata[128:113];
    got.degenerate = m_axis_tuser;
    got.last       = m_axis_tlast;
  end

  initial mismatches = 0;
  assign rows_pending = expected_rows.size();

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) predict_rotation(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_rows.size() == 0) begin
          mismatches++;
          $display("%0t unexpected row beat: expected none, actual %p", $time, got);
        end else begin
          want = expected_rows.pop_front();
          if (got.row !== want.row || got.q_w !== want.q_w || got.q_x !== want.q_x ||
              got.q_y !== want.q_y || got.q_z !== want.q_z || got.col0 !== want.col0 ||
              got.col1 !== want.col1 || got.col2 !== want.col2 ||
              got.inf_norm !== want.inf_norm || got.degenerate !== want.degenerate ||
              got.last !== want.last) begin
            mismatches++;
            $display("%0t row mismatch: expected %p, actual %p", $time, want, got);
          end
        end
      end
    end
  end
endmodule

// File: sim/tb_vector_pair_rotation_matrix.sv
module tb_vector_pair_rotation_matrix;
  // Q1.14 unit scale
  localparam int UNIT = 16384;
  localparam int DRAIN = 2 * 14 + 80;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  // ax, ay, az, bx, by, bz, 16 bits each from the lowest bit up
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  // row, q_w, q_x, q_y, q_z, col0, col1, col2, inf_norm, zero pad
  logic [135:0] m_axis_tdata;
  // degenerate
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  int mismatches, rows_pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  vector_pair_rotation_matrix dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  vprm_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .mismatches(mismatches), .rows_pending(rows_pending)
  );

  // Stall the result side at the rate of the current phase.
  always @(posedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Hold a vector pair on the input until the block takes the beat.
  task automatic send_pair(input logic [47:0] a, input logic [47:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {b, a};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [47:0] vec3(input int x, input int y, input int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  // Random direction scaled to unit length in Q1.14.
  function automatic logic [47:0] unit_vec();
    real fx, fy, fz, len;
    int ix, iy, iz;
    do begin
      fx = $urandom_range(32768) - 16384.0;
      fy = $urandom_range(32768) - 16384.0;
      fz = $urandom_range(32768) - 16384.0;
      len = $sqrt(fx * fx + fy * fy + fz * fz);
    end while (len < 100.0);
    ix = $rtoi(fx * UNIT / len + (fx < 0 ? -0.5 : 0.5));
    iy = $rtoi(fy * UNIT / len + (fy < 0 ? -0.5 : 0.5));
    iz = $rtoi(fz * UNIT / len + (fz < 0 ? -0.5 : 0.5));
    return vec3(ix, iy, iz);
  endfunction

  function automatic logic [47:0] negate(input logic [47:0] v);
    return vec3(-int'($signed(v[15:0])), -int'($signed(v[31:16])),
                -int'($signed(v[47:32])));
  endfunction

  // Nudge one component by a small amount to land near a given direction.
  function automatic logic [47:0] jitter(input logic [47:0] v);
    int k;
    k = $urandom_range(2);
    v[16*k +: 16] = v[16*k +: 16] + 16'($urandom_range(6)) - 16'd3;
    return v;
  endfunction

  task automatic random_pair();
    logic [47:0] a, b;
    int pick;
    pick = $urandom_range(99);
    a = unit_vec();
    if (pick < 60)      b = unit_vec();
    else if (pick < 70) b = negate(a);
    else if (pick < 78) b = jitter(negate(a));
    else if (pick < 85) b = jitter(a);
    else begin
      // raw bit patterns, out of range included
      a = {16'($urandom), 16'($urandom), 16'($urandom)};
      b = {16'($urandom), 16'($urandom), 16'($urandom)};
    end
    send_pair(a, b);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: same, opposite, orthogonal axes, zero vectors, near-opposite pairs and extremes.
    send_pair(vec3(UNIT, 0, 0), vec3(UNIT, 0, 0));
    send_pair(vec3(UNIT, 0, 0), vec3(-UNIT, 0, 0));
    send_pair(vec3(0, -UNIT, 0), vec3(0, UNIT, 0));
    send_pair(vec3(0, 0, UNIT), vec3(0, 0, -UNIT));
    send_pair(vec3(UNIT, 0, 0), vec3(0, UNIT, 0));
    send_pair(vec3(0, UNIT, 0), vec3(0, 0, UNIT));
    send_pair(vec3(0, 0, UNIT), vec3(UNIT, 0, 0));
    send_pair(vec3(-UNIT, 0, 0), vec3(0, 0, -UNIT));
    send_pair(vec3(0, 0, 0), vec3(0, 0, 0));
    send_pair(vec3(0, 0, 0), vec3(UNIT, UNIT, UNIT));
    // near-opposite: 1+c scaled to 1 (degenerate) and to 3 (tiny w)
    send_pair(vec3(UNIT, 1, 0), vec3(-UNIT, 1, 0));
    send_pair(vec3(UNIT, 1, 0), vec3(-UNIT, 3, 0));
    send_pair(vec3(UNIT, 0, 1), vec3(-UNIT, 0, 2));
    send_pair(vec3(32767, 32767, 32767), vec3(32767, 32767, 32767));
    send_pair(vec3(-32768, -32768, -32768), vec3(-32768, -32768, -32768));
    send_pair(vec3(32767, -32768, 32767), vec3(-32768, 32767, -32768));
    send_pair(vec3(-32768, 0, 0), vec3(32767, 0, 0));
    send_pair(vec3(UNIT, UNIT, UNIT), vec3(-UNIT, UNIT, -UNIT));
    send_pair(vec3(11585, 11585, 0), vec3(0, 11585, 11585));
    send_pair(vec3(11585, 0, -11585), vec3(-11585, 0, 11585));

    // Random, in three idling phases.
    send_idle_pct = 18; recv_stall_pct = 79;
    repeat (143) random_pair();
    send_idle_pct = 79; recv_stall_pct = 18;
    repeat (143) random_pair();
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (144) random_pair();
    s_axis_tvalid <= 0;

    // Drain outstanding rows, then let the pipeline settle.
    while (rows_pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && rows_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end
endmodule

// File: vector_pair_rotation_matrix.f
sv/vprm_pkg.sv
sv/vprm_core.sv
sv/vector_pair_rotation_matrix.sv
sim/vprm_checker.sv
sim/tb_vector_pair_rotation_matrix.sv
